// File: sv/repgap_pkg.sv
`timescale 1ns / 1ps

package repgap_pkg;

   // item kinds carried in req_tuser
   localparam logic KIND_PACKET  = 1'b0;
   localparam logic KIND_SEGMENT = 1'b1;

   // replay extension match
   localparam logic [15:0] EXT_ID    = 16'hABAC;
   localparam logic [15:0] EXT_WORDS = 16'd3;

   // fixed point conversion
   localparam int unsigned SECS_W    = 32;
   localparam int unsigned NS_W      = 62;
   localparam int unsigned NSEC_W    = 30;
   localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [NS_W-1:0] TIME_NONE_NS = 62'd4294967295999999999;

   // register reset value
   localparam logic [7:0] GAP_LIMIT_RESET = 8'd5;

   // flag byte bit positions
   localparam int unsigned FLAG_C = 7;
   localparam int unsigned FLAG_E = 6;
   localparam int unsigned FLAG_D = 5;
   localparam int unsigned FLAG_T = 4;

   // request tdata layout, lowest bit first
   localparam int unsigned REQ_SEGREV_LSB  = 0;
   localparam int unsigned REQ_PRESENT_LSB = 1;
   localparam int unsigned REQ_PROFILE_LSB = 2;
   localparam int unsigned REQ_LENGTH_LSB  = 18;
   localparam int unsigned REQ_SECS_LSB    = 34;
   localparam int unsigned REQ_FRAC_LSB    = 66;
   localparam int unsigned REQ_FLAGS_LSB   = 98;
   localparam int unsigned REQ_USED_W      = 106;
   localparam int unsigned REQ_DATA_W      = 112;

   // response tdata layout, lowest bit first
   localparam int unsigned RSP_NONE_BIT = 62;
   localparam int unsigned RSP_KEY_BIT  = 63;
   localparam int unsigned RSP_DISC_BIT = 64;
   localparam int unsigned RSP_EOS_BIT  = 65;
   localparam int unsigned RSP_GAP_BIT  = 66;
   localparam int unsigned RSP_DATA_W   = 72;

   // pipeline control toward the nanosecond unit
   typedef struct packed {
      logic mul_en;
      logic add_en;
      logic found;
   } time_ctl_type;

endpackage

// File: sv/replay_extension_parse_gap_detect.sv
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tdata: packet fields, tuser: kind
// rsp      out        rsp_tvalid/rsp_tready  tdata: time and flags, tuser: ext_found
// csr      in         csr_valid/csr_ready    csr_data: gap limit in seconds
//
// one item per cycle sustained while rsp_tready stays high; a taken item passes the
// input register, the middle register (constant multiplies) and the result register (final add)
// exactly one result per item, in order, for packets and segment starts alike
// reset is synchronous and active high; the gap limit returns to 5 seconds
// a stalled rsp holds the three pipeline registers, then req_tready drops
// csr_ready is always high

module replay_extension_parse_gap_detect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // segment_reverse, ext_present, ext_profile_id, ext_length_words,
   // ntp_seconds, ntp_fraction, flag_byte, zero fill
   input  logic [repgap_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // time_ns, time_none, clean_point, discontinuity, end_of_stream,
   // gap_event, zero fill
   output logic [repgap_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // ext_found
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [7:0]                          csr_data
);
   import repgap_pkg::*;

   // handshake and pipeline movement
   logic                  req_accept;
   logic                  out_ready;
   logic                  mid_ready;
   logic                  in_adv;
   logic                  mid_adv;
   time_ctl_type          ns_ctl;

   // input register
   logic                  in_valid_ff;
   logic                  in_kind_ff;
   logic [REQ_USED_W-1:0] in_data_ff;

   // middle register
   logic                  mid_valid_ff;
   logic                  mid_found_ff;
   logic                  mid_none_ff;
   logic                  mid_key_ff;
   logic                  mid_disc_ff;
   logic                  mid_eos_ff;
   logic                  mid_gap_ff;
   logic                  mid_found_in;
   logic                  mid_none_in;
   logic                  mid_gap_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic                  rsp_none_ff;
   logic                  rsp_key_ff;
   logic                  rsp_disc_ff;
   logic                  rsp_eos_ff;
   logic                  rsp_gap_ff;
   logic [NS_W-1:0]       time_ns;

   // state
   logic [7:0]            gap_limit_ff;
   logic                  first_packet_ff;
   logic                  reverse_mode_ff;
   logic [SECS_W-1:0]     last_key_ff;
   logic                  gap_pending_ff;
   logic                  first_packet_in;
   logic                  reverse_mode_in;
   logic [SECS_W-1:0]     last_key_in;
   logic                  gap_pending_in;

   // decoded fields
   logic                  f_segrev;
   logic                  f_present;
   logic [15:0]           f_profile;
   logic [15:0]           f_length;
   logic [SECS_W-1:0]     f_secs;
   logic [SECS_W-1:0]     f_frac;
   logic [7:0]            f_flags;
   logic                  is_segment;
   logic                  match;
   logic                  key;
   logic                  rev_check;
   logic [SECS_W-1:0]     diff;
   logic                  rev_gap;

   // pipeline movement, req_tready depends combinationally on rsp_tready
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign mid_ready  = !mid_valid_ff || out_ready;
   assign req_tready = !in_valid_ff || mid_ready;
   assign req_accept = req_tvalid && req_tready;
   assign in_adv     = in_valid_ff && mid_ready;
   assign mid_adv    = mid_valid_ff && out_ready;
   assign csr_ready  = 1'b1;

   // field extraction
   assign f_segrev  = in_data_ff[REQ_SEGREV_LSB];
   assign f_present = in_data_ff[REQ_PRESENT_LSB];
   assign f_profile = in_data_ff[REQ_PROFILE_LSB +: 16];
   assign f_length  = in_data_ff[REQ_LENGTH_LSB +: 16];
   assign f_secs    = in_data_ff[REQ_SECS_LSB +: SECS_W];
   assign f_frac    = in_data_ff[REQ_FRAC_LSB +: SECS_W];
   assign f_flags   = in_data_ff[REQ_FLAGS_LSB +: 8];

   assign is_segment = (in_kind_ff == KIND_SEGMENT);
   assign match      = !is_segment && f_present && (f_profile == EXT_ID)
                       && (f_length == EXT_WORDS);
   assign key        = f_flags[FLAG_C];

   // reverse key-frame distance over the full 32-bit seconds
   assign rev_check = key && reverse_mode_ff && !first_packet_ff;
   assign diff      = (f_secs >= last_key_ff) ? (f_secs - last_key_ff)
                                              : (last_key_ff - f_secs);
   assign rev_gap   = rev_check && (diff > SECS_W'(gap_limit_ff));

   // state and result of the item in the input register
   always_comb begin
      first_packet_in = first_packet_ff;
      reverse_mode_in = reverse_mode_ff;
      last_key_in     = last_key_ff;
      gap_pending_in  = gap_pending_ff;
      mid_found_in    = 1'b0;
      mid_gap_in      = 1'b0;
      if (is_segment) begin
         first_packet_in = 1'b1;
         reverse_mode_in = f_segrev;
      end else if (match) begin
         mid_found_in    = 1'b1;
         if (first_packet_ff || rev_check) begin
            last_key_in = f_secs;
         end
         // pending forward gap fires here, reverse drops it silently
         mid_gap_in      = rev_gap || (gap_pending_ff && !reverse_mode_ff);
         gap_pending_in  = f_flags[FLAG_E];
         first_packet_in = 1'b0;
      end
   end

   assign mid_none_in = match && (&f_secs) && (&f_frac);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         mid_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         gap_limit_ff    <= GAP_LIMIT_RESET;
         first_packet_ff <= 1'b1;
         reverse_mode_ff <= 1'b0;
         last_key_ff     <= '0;
         gap_pending_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (mid_ready) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= mid_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            gap_limit_ff <= csr_data;
         end
         if (in_adv) begin
            first_packet_ff <= first_packet_in;
            reverse_mode_ff <= reverse_mode_in;
            last_key_ff     <= last_key_in;
            gap_pending_ff  <= gap_pending_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata[REQ_USED_W-1:0];
      end
      if (in_adv) begin
         mid_found_ff <= mid_found_in;
         mid_none_ff  <= mid_none_in;
         mid_key_ff   <= match && key;
         mid_disc_ff  <= match && f_flags[FLAG_D];
         mid_eos_ff   <= match && f_flags[FLAG_T];
         mid_gap_ff   <= mid_gap_in;
      end
      if (mid_adv) begin
         rsp_found_ff <= mid_found_ff;
         rsp_none_ff  <= mid_none_ff;
         rsp_key_ff   <= mid_key_ff;
         rsp_disc_ff  <= mid_disc_ff;
         rsp_eos_ff   <= mid_eos_ff;
         rsp_gap_ff   <= mid_gap_ff;
      end
   end

   // nanosecond conversion, aligned with the middle and result registers
   assign ns_ctl.mul_en = in_adv;
   assign ns_ctl.add_en = mid_adv;
   assign ns_ctl.found  = mid_found_ff;

   repgap_ns u_ns (
      .clock   (clock),
      .ctl     (ns_ctl),
      .secs    (f_secs),
      .frac    (f_frac),
      .time_ns (time_ns)
   );

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_GAP_BIT-1)'(0), rsp_gap_ff, rsp_eos_ff,
                        rsp_disc_ff, rsp_key_ff, rsp_none_ff, time_ns};

   // input side stalls only when every stage is full and the result waits
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && mid_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled with room in the pipeline");

   // an item without a matching extension gives an all-zero result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("unmatched item carries nonzero fields");

   // the all-ones timestamp converts to its known nanosecond value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_NONE_BIT]) |-> (time_ns == TIME_NONE_NS))
      else $error("no-time value converted wrongly");

   // a decoded packet with E set leaves a pending gap behind
   assert property (@(posedge clock) disable iff (reset)
      (in_adv && match && f_flags[FLAG_E]) |=> gap_pending_ff)
      else $error("E bit did not set the pending gap");

   // a gap is only reported on a decoded packet
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_GAP_BIT]) |-> rsp_tuser)
      else $error("gap reported without an extension");

endmodule

// File: sv/repgap_ns.sv
`timescale 1ns / 1ps

module repgap_ns (
   input  logic                             clock,
   input  repgap_pkg::time_ctl_type         ctl,
   input  logic [repgap_pkg::SECS_W-1:0]    secs,
   input  logic [repgap_pkg::SECS_W-1:0]    frac,
   output logic [repgap_pkg::NS_W-1:0]      time_ns
);
   import repgap_pkg::*;

   logic [NS_W-1:0]   secs_prod_in;
   logic [NS_W-1:0]   secs_prod_ff;
   logic [NS_W-1:0]   frac_prod;
   logic [NSEC_W-1:0] frac_ns_in;
   logic [NSEC_W-1:0] frac_ns_ff;
   logic [NS_W-1:0]   time_ns_in;
   logic [NS_W-1:0]   time_ns_ff;

   // first step: two constant multiplies
   assign secs_prod_in = NS_W'(secs) * NS_W'(NS_PER_SEC);
   assign frac_prod    = NS_W'(frac) * NS_W'(NS_PER_SEC);
   assign frac_ns_in   = frac_prod[NS_W-1:SECS_W];

   // second step: sum, zero when no extension matched
   assign time_ns_in = ctl.found ? (secs_prod_ff + NS_W'(frac_ns_ff)) : '0;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         secs_prod_ff <= secs_prod_in;
         frac_ns_ff   <= frac_ns_in;
      end
      if (ctl.add_en) begin
         time_ns_ff <= time_ns_in;
      end
   end

   assign time_ns = time_ns_ff;

endmodule

// File: bench/replay_extension_parse_gap_detect_test.sv
`timescale 1ns / 1ps

module replay_extension_parse_gap_detect_test;
   import repgap_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 300;
   localparam int SETTLE_CYCLES = 4;

   // one request item, unpacked into its fields
   typedef struct packed {
      logic        kind;
      logic        seg_reverse;
      logic        present;
      logic [15:0] profile;
      logic [15:0] length_words;
      logic [31:0] secs;
      logic [31:0] frac;
      logic [7:0]  flags;
   } header_item_type;

   // one decoded result
   typedef struct packed {
      logic            found;
      logic [NS_W-1:0] time_ns;
      logic            time_none;
      logic            key;
      logic            disc;
      logic            eos;
      logic            gap;
   } header_result_type;

   // tracks decoder state and the results still owed by the block
   class gap_scoreboard_type;
      logic [7:0]        gap_limit;
      bit                first_pkt;
      bit                rev_mode;
      bit [31:0]         last_key_secs;
      bit                gap_armed;
      header_result_type predicted_results[$];
      int                errors;
      int                n_decoded, n_rejected, n_segments, n_gaps, n_time_none;

      function new();
         gap_limit     = GAP_LIMIT_RESET;
         first_pkt     = 1'b1;
         rev_mode      = 1'b0;
         last_key_secs = '0;
         gap_armed     = 1'b0;
         errors        = 0;
      endfunction

      function void set_gap(input logic [7:0] value);
         gap_limit = value;
      endfunction

      function int pending();
         return predicted_results.size();
      endfunction

      // work out the result that an accepted item must cause
      function void note_item(input header_item_type it);
         header_result_type r;
         bit [63:0]         frac_ns, total_ns;
         bit [31:0]         diff;
         bit                gap;
         r   = '0;
         gap = 1'b0;
         if (it.kind == KIND_SEGMENT) begin
            first_pkt = 1'b1;
            rev_mode  = it.seg_reverse;
            n_segments++;
         end else if (it.present && it.profile == EXT_ID && it.length_words == EXT_WORDS) begin
            frac_ns  = (64'(it.frac) * 64'(NS_PER_SEC)) >> 32;
            total_ns = 64'(it.secs) * 64'(NS_PER_SEC) + frac_ns;
            if (first_pkt)
               last_key_secs = it.secs;
            // reverse playback: key frames too far apart
            if (it.flags[FLAG_C] && rev_mode && !first_pkt) begin
               diff = (it.secs >= last_key_secs) ? it.secs - last_key_secs
                                                 : last_key_secs - it.secs;
               if (diff > {24'd0, gap_limit})
                  gap = 1'b1;
               last_key_secs = it.secs;
            end
            // forward playback: packet after an E bit
            if (gap_armed) begin
               gap_armed = 1'b0;
               if (!rev_mode)
                  gap = 1'b1;
            end
            if (it.flags[FLAG_E])
               gap_armed = 1'b1;
            first_pkt   = 1'b0;
            r.found     = 1'b1;
            r.time_ns   = total_ns[NS_W-1:0];
            r.time_none = (&it.secs) && (&it.frac);
            r.key       = it.flags[FLAG_C];
            r.disc      = it.flags[FLAG_D];
            r.eos       = it.flags[FLAG_T];
            r.gap       = gap;
            n_decoded++;
            if (gap)
               n_gaps++;
            if (r.time_none)
               n_time_none++;
         end else begin
            n_rejected++;
         end
         predicted_results.push_back(r);
      endfunction

      task report(input string what, input logic [63:0] got, input logic [63:0] want);
         errors++;
         $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      endtask

      // compare one accepted result against the oldest prediction
      task check_result(input logic [RSP_DATA_W-1:0] data, input logic found);
         header_result_type want;
         if (predicted_results.size() == 0) begin
            report("unexpected result", {63'd0, found}, 64'd0);
            return;
         end
         want = predicted_results.pop_front();
         if (found !== want.found)
            report("ext_found", 64'(found), 64'(want.found));
         if (data[NS_W-1:0] !== want.time_ns)
            report("time_ns", 64'(data[NS_W-1:0]), 64'(want.time_ns));
         if (data[RSP_NONE_BIT] !== want.time_none)
            report("time_none", 64'(data[RSP_NONE_BIT]), 64'(want.time_none));
         if (data[RSP_KEY_BIT] !== want.key)
            report("clean_point", 64'(data[RSP_KEY_BIT]), 64'(want.key));
         if (data[RSP_DISC_BIT] !== want.disc)
            report("discontinuity", 64'(data[RSP_DISC_BIT]), 64'(want.disc));
         if (data[RSP_EOS_BIT] !== want.eos)
            report("end_of_stream", 64'(data[RSP_EOS_BIT]), 64'(want.eos));
         if (data[RSP_GAP_BIT] !== want.gap)
            report("gap_event", 64'(data[RSP_GAP_BIT]), 64'(want.gap));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [7:0]            csr_data;

   gap_scoreboard_type sb = new();

   bit        idle_on = 1'b1;
   int        hold_request = 0;
   int        cycles = 0;
   bit [31:0] base_secs = 32'd1000;

   replay_extension_parse_gap_detect dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results owed", cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      static int hold_left = 0;
      static int stall_left = 0;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = idle_len();
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   function automatic header_item_type packet(input logic [31:0] secs,
                                              input logic [31:0] frac,
                                              input logic [7:0] flags);
      header_item_type it;
      it              = '0;
      it.kind         = KIND_PACKET;
      it.present      = 1'b1;
      it.profile      = EXT_ID;
      it.length_words = EXT_WORDS;
      it.secs         = secs;
      it.frac         = frac;
      it.flags        = flags;
      return it;
   endfunction

   function automatic header_item_type segment(input logic rev);
      header_item_type it;
      it             = '0;
      it.kind        = KIND_SEGMENT;
      it.seg_reverse = rev;
      return it;
   endfunction

   // mostly well-formed replay headers around a drifting time, some noise
   function automatic header_item_type random_item();
      header_item_type it;
      int              r;
      int unsigned     g;
      r = $urandom_range(0, 99);
      g = sb.gap_limit;
      it = packet($urandom, $urandom, 8'($urandom_range(0, 255)));
      if (r < 6) begin
         // segment start with junk in the unused fields
         it.kind         = KIND_SEGMENT;
         it.seg_reverse  = 1'($urandom_range(0, 1));
         it.present      = 1'($urandom_range(0, 1));
         it.profile      = 16'($urandom);
         it.length_words = 16'($urandom);
      end else if (r < 86) begin
         case ($urandom_range(0, 19))
            0: base_secs = $urandom;
            1: base_secs = 32'hFFFF_FFF8;
            2: base_secs = 32'd3;
            default: ;
         endcase
         it.secs = base_secs + $urandom_range(0, 2 * g + 4) - (g + 2);
         base_secs = it.secs;
         case ($urandom_range(0, 29))
            0: begin
               it.secs = '1;
               it.frac = '1;
            end
            1: it.frac = '1;
            2: it.frac = '0;
            default: ;
         endcase
         it.flags[FLAG_E] = ($urandom_range(0, 4) == 0);
      end else begin
         // broken or foreign extensions
         it.seg_reverse = 1'($urandom_range(0, 1));
         it.present     = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1))
            it.profile = 16'($urandom);
         case ($urandom_range(0, 3))
            0: it.length_words = 16'($urandom);
            1: it.length_words = EXT_WORDS + 16'd1;
            2: it.length_words = EXT_WORDS - 16'd1;
            default: ;
         endcase
      end
      return it;
   endfunction

   // offer one item and wait until the block takes it
   task automatic send_item(input header_item_type it);
      int                    gap;
      logic [REQ_DATA_W-1:0] packed_data;
      gap = idle_len();
      packed_data                              = '0;
      packed_data[REQ_SEGREV_LSB]              = it.seg_reverse;
      packed_data[REQ_PRESENT_LSB]             = it.present;
      packed_data[REQ_PROFILE_LSB +: 16]       = it.profile;
      packed_data[REQ_LENGTH_LSB +: 16]        = it.length_words;
      packed_data[REQ_SECS_LSB +: SECS_W]      = it.secs;
      packed_data[REQ_FRAC_LSB +: 32]          = it.frac;
      packed_data[REQ_FLAGS_LSB +: 8]          = it.flags;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= packed_data;
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // let every owed result come out, then wait SETTLE_CYCLES quiet cycles
   task automatic wait_for_results();
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_gap(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] gap_value;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_PACKET;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, rejects, both gap rules, segment handling
      send_item(packet(32'd0, 32'd0, 8'h00));
      send_item(packet('1, '1, 8'hFF));
      send_item(packet(32'd1, 32'h8000_0000, 8'h00));
      begin
         header_item_type odd;
         odd = packet(32'd2, 32'd2, 8'h80);
         odd.present = 1'b0;
         send_item(odd);
         odd = packet(32'd2, 32'd2, 8'h80);
         odd.profile = EXT_ID + 16'd1;
         send_item(odd);
         odd = packet(32'd2, 32'd2, 8'h80);
         odd.length_words = '0;
         send_item(odd);
         odd = packet(32'd2, 32'd2, 8'h80);
         odd.length_words = '1;
         send_item(odd);
         odd = segment(1'b1);
         odd.present      = 1'b1;
         odd.profile      = '1;
         odd.length_words = '1;
         odd.secs         = '1;
         odd.frac         = '1;
         odd.flags        = '1;
         send_item(odd);
      end
      send_item(packet(32'd100, 32'd0, 8'h80));
      send_item(packet(32'd105, 32'd0, 8'h80));
      send_item(packet(32'd111, 32'd0, 8'h80));
      send_item(packet(32'd500, 32'd0, 8'h00));
      send_item(packet(32'd100, 32'd0, 8'h80));
      send_item(packet(32'd100, 32'd0, 8'h40));
      send_item(packet(32'd101, 32'd0, 8'h80));
      send_item(segment(1'b0));
      send_item(packet(32'd7, 32'd5, 8'h40));
      send_item(segment(1'b0));
      send_item(packet(32'd8, 32'd5, 8'h00));
      send_item(segment(1'b1));
      send_item(packet('1, 32'd0, 8'h80));
      send_item(packet(32'd0, 32'd0, 8'h80));
      send_item(packet('1, 32'd0, 8'h00));
      send_item(packet(32'd0, '1, 8'h30));

      // random phases, each under its own gap setting
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            idle_req();
            wait_for_results();
            case (p)
               1: gap_value = 8'd0;
               2: gap_value = 8'd255;
               4: gap_value = 8'd1;
               default: gap_value = 8'($urandom_range(0, 255));
            endcase
            write_gap(gap_value);
         end
         idle_on = (p != 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 100)
               hold_request = 300;
            if (p == 3 && i == 150) begin
               idle_req();
               wait_for_results();
            end
            send_item(random_item());
         end
      end

      idle_req();
      wait_for_results();
      $display("covered %0d decoded headers (%0d without time), %0d rejected, %0d segment starts",
               sb.n_decoded, sb.n_time_none, sb.n_rejected, sb.n_segments);
      $display("%0d gap events over %0d gap settings, %0d mismatches",
               sb.n_gaps, PHASES, sb.errors);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
